>>> design/command_frame_deframer_defines.svh
// assertion helpers shared by the deframer
`ifndef COMMAND_FRAME_DEFRAMER_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_DEFINES_SVH

// implication or plain property, checked outside reset
`define CFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// plain expression that must hold at every edge outside reset
`define CFD_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`endif

>>> design/cfd_pkg.sv
package cfd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_SECOND = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CHK_ERR = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef enum logic {
        CFG_HEADER_FIRST  = 1'b0,
        CFG_HEADER_SECOND = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] HDR_FIRST_RST  = 8'hEB;
    localparam logic [7:0] HDR_SECOND_RST = 8'h53;

    localparam int ARG_OUTS     = 6;
    localparam int CNT_W        = 17;
    localparam int LEN_W        = 16;
    localparam int LEN_LO_POS   = 2;
    localparam int LEN_HI_POS   = 3;
    localparam int CMD_POS      = 4;
    localparam int ARG_POS      = 5;
    localparam int FRAME_EXTRA  = 5;

endpackage

>>> design/command_frame_deframer.sv
// Command frame deframer: takes one received byte per item and finds frames of the form
// header_first, header_second, length low, length high, command, body, checksum, where the
// frame is length + 5 bytes long. Each completed frame gives one result with its status
// (good, checksum mismatch, or empty body), the command byte, the length and frame bytes
// 5 to 10 (0 past the end of the frame or past the CAPTURED_ARGS kept bytes). The checksum
// is the XOR of the command and body bytes. A wrong second header byte is dropped and the
// hunt restarts with the next byte. One byte is taken every clock cycle while input ready
// is high; the byte state is updated in the cycle it is accepted and the result appears in
// the output register on the next cycle. Input ready drops only when a finished result is
// still waiting and the next byte would close another frame. Header registers are written
// through the config port at any time and take effect at the next header compare.
`include "command_frame_deframer_defines.svh"

module command_frame_deframer #(
    parameter int CAPTURED_ARGS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  cfd_pkg::t_cfg_idx          i_cfg_index,
    input  logic [7:0]                 i_cfg_data,

    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_rx_byte,

    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_frame_status,
    output logic [7:0]                 o_command_code,
    output logic [15:0]                o_body_length,
    output logic [7:0]                 o_arg_byte0,
    output logic [7:0]                 o_arg_byte1,
    output logic [7:0]                 o_arg_byte2,
    output logic [7:0]                 o_arg_byte3,
    output logic [7:0]                 o_arg_byte4,
    output logic [7:0]                 o_arg_byte5
);
    import cfd_pkg::*;

    localparam int NSTORE = (CAPTURED_ARGS < ARG_OUTS) ? CAPTURED_ARGS : ARG_OUTS;

    logic [7:0]        r_hdr1;
    logic [7:0]        r_hdr2;
    t_phase            r_phase;
    logic [CNT_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_len;
    logic [7:0]        r_xor;
    logic [7:0]        r_cmd;
    logic [7:0]        r_args [NSTORE];

    logic              r_out_valid;
    t_status           r_status;
    logic [7:0]        r_out_cmd;
    logic [LEN_W-1:0]  r_out_len;
    logic [7:0]        r_out_args [ARG_OUTS];

    logic              w_acc;
    logic              w_last;
    logic [CNT_W-1:0]  w_total;
    logic [CNT_W-1:0]  n_count;
    logic [LEN_W-1:0]  n_len;
    logic [7:0]        n_cmd;
    t_status           n_status;
    logic [7:0]        n_args [ARG_OUTS];

    assign o_cfg_ready = 1'b1;

    // frame closes on this byte; length is settled once the count reaches the command byte
    assign w_total = {1'b0, r_len} + CNT_W'(FRAME_EXTRA);
    assign n_count = r_count + CNT_W'(1);
    assign w_last  = (r_phase == PH_BODY) && (r_count >= CNT_W'(CMD_POS))
                     && (n_count == w_total);

    assign o_in_ready = !(r_out_valid && w_last);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_len = r_len;
        if (r_count == CNT_W'(LEN_LO_POS)) begin
            n_len = {r_len[15:8], i_rx_byte};
        end else if (r_count == CNT_W'(LEN_HI_POS)) begin
            n_len = {i_rx_byte, r_len[7:0]};
        end
        n_cmd = (r_count == CNT_W'(CMD_POS)) ? i_rx_byte : r_cmd;
        if (r_len == '0) begin
            n_status = ST_EMPTY;
        end else if (r_xor == i_rx_byte) begin
            n_status = ST_OK;
        end else begin
            n_status = ST_CHK_ERR;
        end
        for (int j = 0; j < ARG_OUTS; j++) begin
            n_args[j] = 8'd0;
            if (j < NSTORE) begin
                n_args[j] = (r_count == CNT_W'(ARG_POS + j)) ? i_rx_byte : r_args[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr1 <= HDR_FIRST_RST;
            r_hdr2 <= HDR_SECOND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  r_hdr1 <= i_cfg_data;
                CFG_HEADER_SECOND: r_hdr2 <= i_cfg_data;
                default:           r_hdr1 <= r_hdr1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_len   <= '0;
            r_xor   <= '0;
            r_cmd   <= '0;
            for (int j = 0; j < NSTORE; j++) begin
                r_args[j] <= '0;
            end
        end else if (w_acc) begin
            case (r_phase)
                PH_SECOND: begin
                    if (i_rx_byte == r_hdr2) begin
                        r_phase <= PH_BODY;
                        r_count <= CNT_W'(LEN_LO_POS);
                    end else begin
                        r_phase <= PH_IDLE;
                        r_count <= '0;
                    end
                end
                PH_BODY: begin
                    if (w_last) begin
                        r_phase <= PH_IDLE;
                        r_count <= '0;
                        r_len   <= '0;
                        r_xor   <= '0;
                        r_cmd   <= '0;
                        for (int j = 0; j < NSTORE; j++) begin
                            r_args[j] <= '0;
                        end
                    end else begin
                        r_count <= n_count;
                        r_len   <= n_len;
                        r_cmd   <= n_cmd;
                        for (int j = 0; j < NSTORE; j++) begin
                            r_args[j] <= n_args[j];
                        end
                        if (r_count >= CNT_W'(CMD_POS)) begin
                            r_xor <= r_xor ^ i_rx_byte;
                        end
                    end
                end
                default: begin
                    if (i_rx_byte == r_hdr1) begin
                        r_phase <= PH_SECOND;
                        r_count <= CNT_W'(1);
                        r_len   <= '0;
                        r_xor   <= '0;
                        r_cmd   <= '0;
                        for (int j = 0; j < NSTORE; j++) begin
                            r_args[j] <= '0;
                        end
                    end else begin
                        r_phase <= PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_last) begin
            r_status  <= n_status;
            r_out_cmd <= n_cmd;
            r_out_len <= r_len;
            for (int j = 0; j < ARG_OUTS; j++) begin
                r_out_args[j] <= n_args[j];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_status;
    assign o_command_code = r_out_cmd;
    assign o_body_length  = r_out_len;
    assign o_arg_byte0    = r_out_args[0];
    assign o_arg_byte1    = r_out_args[1];
    assign o_arg_byte2    = r_out_args[2];
    assign o_arg_byte3    = r_out_args[3];
    assign o_arg_byte4    = r_out_args[4];
    assign o_arg_byte5    = r_out_args[5];

    `CFD_ASSERT(a_close_emits, (w_acc && w_last) |=> o_out_valid, "closed frame gave no result")
    `CFD_CHECK(a_no_overwrite, !(r_out_valid && !i_out_ready && w_acc && w_last), "result overwritten")
    `CFD_CHECK(a_body_count, (r_phase != PH_BODY) || (r_count >= CNT_W'(LEN_LO_POS)), "body count low")
    `CFD_ASSERT(a_idle_after_close, (w_acc && w_last) |=> (r_phase == PH_IDLE && r_count == '0), "no restart")

endmodule

>>> dv/command_frame_deframer_tb.sv
module command_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfd_pkg::*;

    localparam int KEPT_ARGS   = 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_BYTES = 130;
    localparam int DIR_ROWS    = 32;

    typedef struct packed {
        logic [1:0]      status;
        logic [7:0]      cmd;
        logic [15:0]     len;
        logic [5:0][7:0] args;
    } frame_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        frame_t     want;
    } row_t;

    localparam frame_t NONE = '0;

    // hand-checked frames: empty body, dropped second header, good and bad checksum
    localparam row_t DIRECTED [DIR_ROWS] = '{
        '{8'hEB, 1'b0, NONE}, '{8'h53, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
        '{8'h00, 1'b0, NONE}, '{8'h7A, 1'b1, '{ST_EMPTY, 8'h7A, 16'h0000, 48'h0}},
        '{8'hEB, 1'b0, NONE}, '{8'hEB, 1'b0, NONE}, '{8'h53, 1'b0, NONE},
        '{8'hEB, 1'b0, NONE}, '{8'h53, 1'b0, NONE}, '{8'h01, 1'b0, NONE},
        '{8'h00, 1'b0, NONE}, '{8'hFF, 1'b0, NONE},
        '{8'hFF, 1'b1, '{ST_OK, 8'hFF, 16'h0001, 48'h0000_0000_00FF}},
        '{8'hEB, 1'b0, NONE}, '{8'h53, 1'b0, NONE}, '{8'h01, 1'b0, NONE},
        '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
        '{8'h01, 1'b1, '{ST_CHK_ERR, 8'h00, 16'h0001, 48'h0000_0000_0001}},
        '{8'hEB, 1'b0, NONE}, '{8'h53, 1'b0, NONE}, '{8'h07, 1'b0, NONE},
        '{8'h00, 1'b0, NONE}, '{8'hC3, 1'b0, NONE}, '{8'h11, 1'b0, NONE},
        '{8'h22, 1'b0, NONE}, '{8'h44, 1'b0, NONE}, '{8'h88, 1'b0, NONE},
        '{8'hF0, 1'b0, NONE}, '{8'h0F, 1'b0, NONE}, '{8'hC3, 1'b0, NONE}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_frame_status;
    logic [7:0] o_command_code;
    logic [15:0] o_body_length;
    logic [7:0] o_arg_byte0, o_arg_byte1, o_arg_byte2;
    logic [7:0] o_arg_byte3, o_arg_byte4, o_arg_byte5;

    // deframer state mirror
    logic [7:0]      hdr_first  = HDR_FIRST_RST;
    logic [7:0]      hdr_second = HDR_SECOND_RST;
    t_phase          hunt       = PH_IDLE;
    logic [16:0]     pos        = '0;
    logic [15:0]     len_acc    = '0;
    logic [7:0]      xor_acc    = '0;
    logic [7:0]      cmd_acc    = '0;
    logic [5:0][7:0] args_acc   = '0;

    frame_t pending_frames [$];
    int     errors = 0;
    int     framed = 0;
    bit     calm   = 1'b0;

    command_frame_deframer #(
        .CAPTURED_ARGS(KEPT_ARGS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_status (o_frame_status),
        .o_command_code (o_command_code),
        .o_body_length  (o_body_length),
        .o_arg_byte0    (o_arg_byte0),
        .o_arg_byte1    (o_arg_byte1),
        .o_arg_byte2    (o_arg_byte2),
        .o_arg_byte3    (o_arg_byte3),
        .o_arg_byte4    (o_arg_byte4),
        .o_arg_byte5    (o_arg_byte5)
    );

    always #6 i_clk = ~i_clk;

    function automatic void clear_frame();
        pos      = '0;
        len_acc  = '0;
        xor_acc  = '0;
        cmd_acc  = '0;
        args_acc = '0;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output frame_t fr);
        logic [16:0] at;
        logic [16:0] span;
        bit          done;
        fr   = '0;
        done = 1'b0;
        case (hunt)
            PH_SECOND: begin
                if (b == hdr_second) begin
                    hunt = PH_BODY;
                    pos  = 17'd2;
                end else begin
                    hunt = PH_IDLE;
                    pos  = '0;
                end
            end
            PH_BODY: begin
                at = pos;
                if (at == LEN_LO_POS) len_acc[7:0] = b;
                else if (at == LEN_HI_POS) len_acc[15:8] = b;
                else if (at == CMD_POS) cmd_acc = b;
                if (at >= ARG_POS && at < ARG_POS + KEPT_ARGS)
                    args_acc[3'(at - 17'(ARG_POS))] = b;
                pos  = at + 17'd1;
                span = {1'b0, len_acc} + 17'(FRAME_EXTRA);
                if (pos >= 17'd4 && pos == span) begin
                    if (span < 17'd6) fr.status = ST_EMPTY;
                    else if (xor_acc == b) fr.status = ST_OK;
                    else fr.status = ST_CHK_ERR;
                    fr.cmd  = cmd_acc;
                    fr.len  = len_acc;
                    fr.args = args_acc;
                    done    = 1'b1;
                    hunt    = PH_IDLE;
                    clear_frame();
                end else if (at >= CMD_POS) begin
                    xor_acc = xor_acc ^ b;
                end
            end
            default: begin
                if (b == hdr_first) begin
                    clear_frame();
                    hunt = PH_SECOND;
                    pos  = 17'd1;
                end else begin
                    hunt = PH_IDLE;
                end
            end
        endcase
        return done;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 50) return 16'($urandom_range(1, 6));
        if (r < 90) return 16'($urandom_range(7, 20));
        return 16'($urandom_range(21, 60));
    endfunction

    function automatic logic [7:0] rand_except(input logic [7:0] x);
        logic [7:0] b;
        do b = 8'($urandom); while (b == x);
        return b;
    endfunction

    function automatic void report_frame(input string what, input frame_t want,
                                         input frame_t seen);
        errors++;
        if (errors <= 10) begin
            $display("%s: want st=%0d cmd=%02h len=%04h args=%012h", what, want.status,
                     want.cmd, want.len, want.args);
            $display("    got st=%0d cmd=%02h len=%04h args=%012h", seen.status, seen.cmd,
                     seen.len, seen.args);
        end
    endfunction

    task automatic feed_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input frame_t want = '0);
        int     gap;
        frame_t fr;
        bit     hit;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        hit = deframe_byte(b, fr);
        if (typed) pending_frames = {pending_frames, want};
        else if (hit) pending_frames = {pending_frames, fr};
    endtask

    task automatic send_frame(input logic [15:0] len, input bit good, input bit resume);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        sum = '0;
        if (!resume) feed_byte(hdr_first);
        feed_byte(hdr_second);
        feed_byte(len[7:0]);
        feed_byte(len[15:8]);
        for (i = 0; i < int'(len); i++) begin
            b   = 8'($urandom);
            sum = sum ^ b;
            feed_byte(b);
        end
        if (len == 16'd0) b = 8'($urandom);
        else if (good) b = sum;
        else b = sum ^ 8'($urandom_range(1, 255));
        feed_byte(b);
        framed += int'(len) + 5;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_HEADER_FIRST) hdr_first = val;
        else hdr_second = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_bytes);
        int start;
        int r;
        int n;
        start = framed;
        while (framed - start < n_bytes) begin
            r    = $urandom_range(0, 99);
            calm = ($urandom_range(0, 7) == 0);
            if (r < 78) begin
                send_frame(pick_len(), $urandom_range(0, 3) != 0, 1'b0);
            end else if (r < 90) begin
                n = $urandom_range(1, 4);
                repeat (n) feed_byte(rand_except(hdr_first));
            end else begin
                feed_byte(hdr_first);
                feed_byte(rand_except(hdr_second));
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        frame_t seen;
        frame_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_frame_status, o_command_code, o_body_length,
                     {o_arg_byte5, o_arg_byte4, o_arg_byte3,
                      o_arg_byte2, o_arg_byte1, o_arg_byte0}};
            if (pending_frames.size() == 0) begin
                report_frame("unexpected frame result", NONE, seen);
            end else begin
                want = pending_frames.pop_front();
                if (seen.status !== want.status || seen.cmd !== want.cmd ||
                    seen.len !== want.len || seen.args !== want.args)
                    report_frame("frame result mismatch", want, seen);
            end
        end
    end

    initial begin
        int hold;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("command_frame_deframer_tb: errors");
        $finish;
    end

    initial begin
        int k;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_HEADER_FIRST;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_rx_byte   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            feed_byte(DIRECTED[k].rx, DIRECTED[k].typed, DIRECTED[k].want);
        drain();

        run_phase(PHASE_BYTES);
        // leave a first header byte waiting, then change both header registers under it
        feed_byte(hdr_first);
        drain();
        write_reg(CFG_HEADER_SECOND, 8'hFF);
        write_reg(CFG_HEADER_FIRST, 8'h00);
        send_frame(pick_len(), 1'b1, 1'b1);
        run_phase(PHASE_BYTES);

        drain();
        write_reg(CFG_HEADER_FIRST, 8'hFF);
        write_reg(CFG_HEADER_SECOND, 8'h00);
        run_phase(PHASE_BYTES);

        drain();
        write_reg(CFG_HEADER_FIRST, 8'h5A);
        write_reg(CFG_HEADER_SECOND, 8'h5A);
        run_phase(PHASE_BYTES);

        drain();
        write_reg(CFG_HEADER_FIRST, 8'($urandom));
        write_reg(CFG_HEADER_SECOND, 8'($urandom));
        run_phase(PHASE_BYTES);

        // long frame with both length bytes set, sent without gaps
        calm = 1'b1;
        send_frame(16'h0105, 1'b1, 1'b0);
        calm = 1'b0;
        send_frame(pick_len(), 1'b0, 1'b0);

        drain();
        repeat (16) @(posedge i_clk);
        if (errors == 0 && pending_frames.size() == 0)
            $display("command_frame_deframer_tb: clean");
        else
            $display("command_frame_deframer_tb: errors");
        $finish;
    end

endmodule
